// ===== rtl/fbps_pkg.sv =====
// Shared types and constants for the first bit position search block.
`timescale 1ns / 1ps

package fbps_pkg;

  // Widths fixed by the word formats.
  localparam int unsigned LenW = 17;
  localparam int unsigned PosW = 21;
  localparam int unsigned IdxW = 20;

  // Position reported when nothing qualifies.
  localparam logic [PosW-1:0] POS_NONE = '1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SEARCH_BIT = 2'd0,
    CFG_RANGE_MODE = 2'd1,
    CFG_START_BYTE = 2'd2,
    CFG_END_BYTE   = 2'd3
  } cfg_reg_e;

  // Range modes; the unused code behaves as start and end given.
  typedef enum logic [1:0] {
    MODE_WHOLE     = 2'd0,
    MODE_START     = 2'd1,
    MODE_START_END = 2'd2
  } range_mode_e;

  // Resolved byte range of one value.
  typedef struct packed {
    logic [LenW-1:0] first;
    logic [LenW-1:0] last;
    logic            empty;
  } range_t;

  // Result of scanning one byte.
  typedef struct packed {
    logic       hit;
    logic [2:0] offset;
  } scan_t;

endpackage

// ===== rtl/first_bit_position_search.sv =====
// Top level of the first bit position search block.
`timescale 1ns / 1ps
// A word that ends its value passes the input register and then the output register, which raises out_valid_o.
// Throughput: one word per cycle; input stalls only while a held result blocks a
// word that produces a result, set by the single output register.
// Reset: configuration returns to its reset values and both stages empty; no clearing pass.

module first_bit_position_search
  import fbps_pkg::*;
#(
  parameter int unsigned MAX_VALUE_BYTES = 65536
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [LenW-1:0]        cfg_data_i,
  // Input words
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             data_byte_i,
  input  logic [LenW-1:0]        value_length_i,
  input  logic                   key_found_i,
  input  logic                   last_byte_i,
  // Result words
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [PosW-1:0] bit_position_o
);

  localparam int unsigned LenMax = (1 << LenW) - 1;
  localparam int unsigned LenCap = (MAX_VALUE_BYTES > LenMax) ? LenMax : MAX_VALUE_BYTES;
  localparam logic [LenW-1:0] LEN_CAP = LenW'(LenCap);

  // Configuration registers.
  logic            search_bit_q;
  logic [1:0]      range_mode_q;
  logic [LenW-1:0] start_byte_q;
  logic [LenW-1:0] end_byte_q;

  // Input stage.
  logic            in_valid_q;
  logic [7:0]      data_q;
  logic [LenW-1:0] len_q;
  logic            found_q;
  logic            last_q;

  // Per-value state.
  logic [LenW-1:0] byte_cnt_q, byte_cnt_d;
  logic [LenW-1:0] rng_first_q, rng_first_d;
  logic [LenW-1:0] rng_last_q, rng_last_d;
  logic            rng_empty_q, rng_empty_d;
  logic            match_seen_q, match_seen_d;
  logic [IdxW-1:0] match_idx_q, match_idx_d;

  // Output stage.
  logic            out_valid_q, out_valid_d;
  logic [PosW-1:0] pos_q, pos_d;

  logic            emits;
  logic            advance;
  logic [LenW-1:0] len_c;
  range_t          new_rng;
  range_t          cur_rng;
  scan_t           scan;
  logic [LenW:0]   cnt_next;
  logic            value_end;
  logic            in_range;
  logic [IdxW-1:0] hit_idx;
  logic            any_match;
  logic [IdxW-1:0] any_idx;

  // Configuration port is always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_bit_q <= 1'b1;
      range_mode_q <= MODE_WHOLE;
      start_byte_q <= '0;
      end_byte_q   <= '1;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_SEARCH_BIT: search_bit_q <= cfg_data_i[0];
        CFG_RANGE_MODE: range_mode_q <= cfg_data_i[1:0];
        CFG_START_BYTE: start_byte_q <= cfg_data_i;
        CFG_END_BYTE:   end_byte_q   <= cfg_data_i;
        default:        search_bit_q <= search_bit_q;
      endcase
    end
  end

  // Input register: loads whenever the stage is empty or moves on.
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q  <= data_byte_i;
      len_q   <= value_length_i;
      found_q <= key_found_i;
      last_q  <= last_byte_i;
    end
  end

  // Length clamp, range resolution and byte scan.
  assign len_c = (len_q > LEN_CAP) ? LEN_CAP : len_q;

  fbps_range u_range (
    .range_mode_i (range_mode_q),
    .start_byte_i (start_byte_q),
    .end_byte_i   (end_byte_q),
    .len_i        (len_c),
    .range_o      (new_rng)
  );

  fbps_scan u_scan (
    .data_i (data_q),
    .bit_i  (search_bit_q),
    .scan_o (scan)
  );

  // The range is taken fresh on the first byte of a value.
  always_comb begin
    if (byte_cnt_q == '0) begin
      cur_rng = new_rng;
    end else begin
      cur_rng.first = rng_first_q;
      cur_rng.last  = rng_last_q;
      cur_rng.empty = rng_empty_q;
    end
  end

  assign cnt_next  = {1'b0, byte_cnt_q} + (LenW+1)'(1);
  assign value_end = last_q || !(cnt_next < {1'b0, len_c});
  assign in_range  = !cur_rng.empty && (byte_cnt_q >= cur_rng.first) &&
                     (byte_cnt_q <= cur_rng.last);
  assign hit_idx   = {byte_cnt_q, scan.offset};
  assign any_match = match_seen_q || (in_range && scan.hit);
  assign any_idx   = match_seen_q ? match_idx_q : hit_idx;

  // Missing keys, empty values and value ends all produce a result.
  assign emits   = !found_q || (len_q == '0) || value_end;
  assign advance = in_valid_q && (!emits || !out_valid_q || out_ready_i);

  // Per-word state update and result selection.
  always_comb begin
    byte_cnt_d   = byte_cnt_q;
    rng_first_d  = rng_first_q;
    rng_last_d   = rng_last_q;
    rng_empty_d  = rng_empty_q;
    match_seen_d = match_seen_q;
    match_idx_d  = match_idx_q;
    pos_d        = pos_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    if (advance) begin
      if (!found_q) begin
        pos_d = search_bit_q ? POS_NONE : '0;
      end else if (len_q == '0) begin
        pos_d = (range_mode_q == MODE_WHOLE && !search_bit_q) ? '0 : POS_NONE;
      end else begin
        if (byte_cnt_q == '0) begin
          rng_first_d = new_rng.first;
          rng_last_d  = new_rng.last;
          rng_empty_d = new_rng.empty;
        end
        if (cur_rng.empty) begin
          pos_d = POS_NONE;
        end else if (any_match) begin
          pos_d = {1'b0, any_idx};
        end else if (search_bit_q || range_mode_q != MODE_WHOLE &&
                     range_mode_q != MODE_START) begin
          pos_d = POS_NONE;
        end else begin
          pos_d = {1'b0, len_c, 3'b000};
        end
        if (!value_end) begin
          byte_cnt_d   = cnt_next[LenW-1:0];
          match_seen_d = any_match;
          match_idx_d  = any_idx;
        end
      end
      if (emits) begin
        out_valid_d  = 1'b1;
        byte_cnt_d   = '0;
        match_seen_d = 1'b0;
        match_idx_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q   <= '0;
      rng_first_q  <= '0;
      rng_last_q   <= '0;
      rng_empty_q  <= 1'b0;
      match_seen_q <= 1'b0;
      match_idx_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      byte_cnt_q   <= byte_cnt_d;
      rng_first_q  <= rng_first_d;
      rng_last_q   <= rng_last_d;
      rng_empty_q  <= rng_empty_d;
      match_seen_q <= match_seen_d;
      match_idx_q  <= match_idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // The result register loads only when a word produces a result, so a held result stays put.
  always_ff @(posedge clk_i) begin
    if (advance && emits) begin
      pos_q <= pos_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign bit_position_o = signed'(pos_q);

endmodule

// ===== rtl/fbps_range.sv =====
// Resolves the configured start and end offsets into a clamped byte range.
`timescale 1ns / 1ps

module fbps_range
  import fbps_pkg::*;
(
  input  logic [1:0]      range_mode_i,
  input  logic [LenW-1:0] start_byte_i,
  input  logic [LenW-1:0] end_byte_i,
  input  logic [LenW-1:0] len_i,
  output range_t          range_o
);

  logic signed [LenW+1:0] len_s;
  logic signed [LenW+1:0] last_idx;
  logic signed [LenW+1:0] s_val;
  logic signed [LenW+1:0] e_val;
  logic                   empty;

  // Offsets are sign extended, wrapped from the end of the value, then clamped.
  always_comb begin
    len_s    = signed'({2'b00, len_i});
    last_idx = len_s - 19'sd1;
    s_val    = '0;
    e_val    = last_idx;
    empty    = 1'b0;
    if (range_mode_i != MODE_WHOLE) begin
      s_val = signed'({{2{start_byte_i[LenW-1]}}, start_byte_i});
      if (s_val < 0) begin
        s_val = s_val + len_s;
      end
      if (s_val < 0) begin
        s_val = '0;
      end
      if (range_mode_i != MODE_START) begin
        e_val = signed'({{2{end_byte_i[LenW-1]}}, end_byte_i});
        if (e_val < 0) begin
          e_val = e_val + len_s;
        end
        if (e_val > last_idx) begin
          e_val = last_idx;
        end
        if (e_val < 0) begin
          e_val = '0;
        end
      end
      empty = (s_val > e_val) || (s_val > last_idx);
    end
  end

  // An empty range reports zero bounds.
  assign range_o.empty = empty;
  assign range_o.first = empty ? '0 : s_val[LenW-1:0];
  assign range_o.last  = empty ? '0 : e_val[LenW-1:0];

endmodule

// ===== rtl/fbps_scan.sv =====
// Priority encoder that finds the first matching bit of a byte, MSB first.
`timescale 1ns / 1ps

module fbps_scan
  import fbps_pkg::*;
(
  input  logic [7:0] data_i,
  input  logic       bit_i,
  output scan_t      scan_o
);

  // Walk from the LSB side so the MSB-most match wins.
  always_comb begin
    scan_o = '0;
    for (int k = 7; k >= 0; k--) begin
      if (data_i[7-k] == bit_i) begin
        scan_o.hit    = 1'b1;
        scan_o.offset = 3'(k);
      end
    end
  end

endmodule

// ===== rtl/fbps_checker.sv =====
// Port-level checks for the first bit position search block, bound to its top level.
`timescale 1ns / 1ps

module fbps_checker
  import fbps_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic signed [PosW-1:0] bit_position_o
);

  // A held result keeps its word until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(bit_position_o))
    else $error("result word changed while stalled");

  // The input side only stalls behind a result that is not being taken.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked result");

  // A new result always traces back to an accepted word that passed the input register and then the output register.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result appeared without an accepted word");

  // Positions are either the no-match code or non-negative.
  a_pos_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bit_position_o == -21'sd1) || !bit_position_o[PosW-1])
    else $error("result position out of form");

endmodule

bind first_bit_position_search fbps_checker u_fbps_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .bit_position_o (bit_position_o)
);
